// ----- hw/rtl/tfn_pkg.sv -----
// tfn_pkg: widths, stage counts and shared types of the triangle face normal core.
// Has no dependencies; every other file of the core uses it.
`default_nettype none

package tfn_pkg;

   localparam int VW   = 24;        // vertex coordinate, Q12.12
   localparam int EW   = VW + 1;    // edge vector component
   localparam int PW   = 2 * EW;    // partial product
   localparam int MW   = 50;        // cross product magnitude
   localparam int NW   = 30;        // normalized magnitude, top bit at 29
   localparam int SW   = 62;        // sum of squares
   localparam int RW   = SW / 2;    // square root
   localparam int QW   = 15;        // quotient
   localparam int DNW  = NW + 14 + 1; // divide numerator
   localparam int OW   = 16;        // normal component, Q1.14
   localparam int PSW  = 6;         // leading-one position
   localparam int GRPS = 7;         // 8-bit groups of the leading-one search

   localparam logic [QW-1:0] UNIT = QW'(16384);

   // LATENCY sums the cross, normalize, root, divide and output stages
   localparam int LATENCY = 3 + 6 + RW + 1 + QW + 1;

   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } side_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tfn_cross.sv -----
// tfn_cross: edge vectors, partial products and cross product magnitudes (3 stages).
// Depends on tfn_pkg.
`default_nettype none

module tfn_cross (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            valid_i,
   input  logic [2:0][tfn_pkg::VW-1:0]     va_i,
   input  logic [2:0][tfn_pkg::VW-1:0]     vb_i,
   input  logic [2:0][tfn_pkg::VW-1:0]     vc_i,
   output logic                            valid_o,
   output logic [2:0][tfn_pkg::MW-1:0]     mag_o,
   output logic [2:0]                      neg_o
);

   logic [2:0] v_ff;
   logic [2:0] v_in;

   logic signed [tfn_pkg::EW-1:0] e1_ff [3];
   logic signed [tfn_pkg::EW-1:0] e2_ff [3];
   logic signed [tfn_pkg::EW-1:0] e1_in [3];
   logic signed [tfn_pkg::EW-1:0] e2_in [3];
   logic signed [tfn_pkg::PW-1:0] p_ff [6];
   logic signed [tfn_pkg::PW-1:0] p_in [6];
   logic [2:0][tfn_pkg::MW-1:0]   mag_ff, mag_in;
   logic [2:0]                    neg_ff, neg_in;
   logic signed [tfn_pkg::PW:0]   c [3];

   assign v_in = {v_ff[1:0], valid_i};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = $signed({vb_i[i][tfn_pkg::VW-1], vb_i[i]})
                  - $signed({va_i[i][tfn_pkg::VW-1], va_i[i]});
         e2_in[i] = $signed({vc_i[i][tfn_pkg::VW-1], vc_i[i]})
                  - $signed({va_i[i][tfn_pkg::VW-1], va_i[i]});
      end
      // index 0 = x, 1 = y, 2 = z
      p_in[0] = e1_ff[1] * e2_ff[2];
      p_in[1] = e1_ff[2] * e2_ff[1];
      p_in[2] = e1_ff[2] * e2_ff[0];
      p_in[3] = e1_ff[0] * e2_ff[2];
      p_in[4] = e1_ff[0] * e2_ff[1];
      p_in[5] = e1_ff[1] * e2_ff[0];
      for (int i = 0; i < 3; i++) begin
         c[i] = $signed({p_ff[2*i][tfn_pkg::PW-1], p_ff[2*i]})
              - $signed({p_ff[2*i+1][tfn_pkg::PW-1], p_ff[2*i+1]});
         neg_in[i] = c[i][tfn_pkg::PW];
         mag_in[i] = neg_in[i] ? tfn_pkg::MW'(-c[i]) : tfn_pkg::MW'(c[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      e1_ff  <= e1_in;
      e2_ff  <= e2_in;
      p_ff   <= p_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
   end

   assign valid_o = v_ff[2];
   assign mag_o   = mag_ff;
   assign neg_o   = neg_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/tfn_norm.sv -----
// tfn_norm: leading-one search, common shift, squares and their sum (6 stages).
// Depends on tfn_pkg.
`default_nettype none

module tfn_norm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_i,
   input  logic [2:0][tfn_pkg::MW-1:0]   mag_i,
   input  logic [2:0]                    neg_i,
   output logic                          valid_o,
   output logic [tfn_pkg::SW-1:0]        sum_o,
   output logic [2:0][tfn_pkg::NW-1:0]   nmag_o,
   output tfn_pkg::side_type             side_o
);

   localparam int OWID = tfn_pkg::GRPS * 8;

   logic [5:0] v_ff, v_in;

   // stage 4
   logic [2:0][tfn_pkg::MW-1:0] m4_ff;
   logic [2:0]                  n4_ff;
   logic [OWID-1:0]             or4_ff, or4_in;
   // stage 5
   logic [2:0][tfn_pkg::MW-1:0] m5_ff;
   logic [2:0]                  n5_ff;
   logic [tfn_pkg::GRPS-1:0]    nz5_ff, nz5_in;
   logic [2:0]                  lp5_ff [tfn_pkg::GRPS];
   logic [2:0]                  lp5_in [tfn_pkg::GRPS];
   // stage 6
   logic [2:0][tfn_pkg::MW-1:0] m6_ff;
   tfn_pkg::side_type           s6_ff, s6_in;
   logic [tfn_pkg::PSW-1:0]     pos6_ff, pos6_in;
   // stage 7
   logic [2:0][tfn_pkg::NW-1:0] m7_ff, m7_in;
   tfn_pkg::side_type           s7_ff;
   // stage 8
   logic [2:0][tfn_pkg::NW-1:0] m8_ff;
   tfn_pkg::side_type           s8_ff;
   logic [2*tfn_pkg::NW-1:0]    sq8_ff [3];
   logic [2*tfn_pkg::NW-1:0]    sq8_in [3];
   // stage 9
   logic [2:0][tfn_pkg::NW-1:0] m9_ff;
   tfn_pkg::side_type           s9_ff;
   logic [tfn_pkg::SW-1:0]      sum9_ff, sum9_in;

   logic [tfn_pkg::MW-1:0]      wide;

   assign v_in = {v_ff[4:0], valid_i};

   always_comb begin
      or4_in = OWID'(mag_i[0] | mag_i[1] | mag_i[2]);
      for (int g = 0; g < tfn_pkg::GRPS; g++) begin
         nz5_in[g] = |or4_ff[8*g +: 8];
         lp5_in[g] = '0;
         for (int b = 0; b < 8; b++) begin
            if (or4_ff[8*g + b]) lp5_in[g] = 3'(b);
         end
      end
      pos6_in = '0;
      for (int g = 0; g < tfn_pkg::GRPS; g++) begin
         if (nz5_ff[g]) pos6_in = {3'(g), lp5_ff[g]};
      end
      s6_in.neg   = n5_ff;
      s6_in.degen = ~|nz5_ff;
      // bring the largest magnitude into [2^29, 2^30)
      for (int i = 0; i < 3; i++) begin
         if (pos6_ff >= tfn_pkg::PSW'(tfn_pkg::NW)) begin
            wide = m6_ff[i] >> (pos6_ff - tfn_pkg::PSW'(tfn_pkg::NW - 1));
         end else begin
            wide = m6_ff[i] << (tfn_pkg::PSW'(tfn_pkg::NW - 1) - pos6_ff);
         end
         m7_in[i] = wide[tfn_pkg::NW-1:0];
      end
      for (int i = 0; i < 3; i++) begin
         sq8_in[i] = m7_ff[i] * m7_ff[i];
      end
      sum9_in = tfn_pkg::SW'(sq8_ff[0]) + tfn_pkg::SW'(sq8_ff[1])
              + tfn_pkg::SW'(sq8_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      m4_ff   <= mag_i;
      n4_ff   <= neg_i;
      or4_ff  <= or4_in;
      m5_ff   <= m4_ff;
      n5_ff   <= n4_ff;
      nz5_ff  <= nz5_in;
      lp5_ff  <= lp5_in;
      m6_ff   <= m5_ff;
      s6_ff   <= s6_in;
      pos6_ff <= pos6_in;
      m7_ff   <= m7_in;
      s7_ff   <= s6_ff;
      m8_ff   <= m7_ff;
      s8_ff   <= s7_ff;
      sq8_ff  <= sq8_in;
      m9_ff   <= m8_ff;
      s9_ff   <= s8_ff;
      sum9_ff <= sum9_in;
   end

   assign valid_o = v_ff[5];
   assign sum_o   = sum9_ff;
   assign nmag_o  = m9_ff;
   assign side_o  = s9_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/tfn_isqrt.sv -----
// tfn_isqrt: pipelined integer square root, one root bit per stage.
// Depends on tfn_pkg; magnitudes and side info ride along.
`default_nettype none

module tfn_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_i,
   input  logic [tfn_pkg::SW-1:0]        sum_i,
   input  logic [2:0][tfn_pkg::NW-1:0]   nmag_i,
   input  tfn_pkg::side_type             side_i,
   output logic                          valid_o,
   output logic [tfn_pkg::RW-1:0]        root_o,
   output logic [2:0][tfn_pkg::NW-1:0]   nmag_o,
   output tfn_pkg::side_type             side_o
);

   localparam int N   = tfn_pkg::RW;
   localparam int RMW = tfn_pkg::RW + 2;

   logic                        v_ff    [N];
   logic [tfn_pkg::SW-1:0]      s_ff    [N];
   logic [N-1:0]                root_ff [N];
   logic [RMW-1:0]              rem_ff  [N];
   logic [2:0][tfn_pkg::NW-1:0] m_ff    [N];
   tfn_pkg::side_type           sd_ff   [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic                        v_prev;
      logic [tfn_pkg::SW-1:0]      s_prev;
      logic [N-1:0]                root_prev, root_in;
      logic [RMW-1:0]              rem_prev, rem_in;
      logic [2:0][tfn_pkg::NW-1:0] m_prev;
      tfn_pkg::side_type           sd_prev;
      logic [RMW+1:0]              pre, trial;

      if (k == 0) begin : g_first
         assign v_prev    = valid_i;
         assign s_prev    = sum_i;
         assign root_prev = '0;
         assign rem_prev  = '0;
         assign m_prev    = nmag_i;
         assign sd_prev   = side_i;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign s_prev    = s_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign m_prev    = m_ff[k-1];
         assign sd_prev   = sd_ff[k-1];
      end

      always_comb begin
         pre   = {rem_prev, s_prev[2*(N-1-k) +: 2]};
         trial = (RMW+2)'({root_prev, 2'b01});
         if (pre >= trial) begin
            rem_in  = RMW'(pre - trial);
            root_in = {root_prev[N-2:0], 1'b1};
         end else begin
            rem_in  = RMW'(pre);
            root_in = {root_prev[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         s_ff[k]    <= s_prev;
         root_ff[k] <= root_in;
         rem_ff[k]  <= rem_in;
         m_ff[k]    <= m_prev;
         sd_ff[k]   <= sd_prev;
      end
   end

   assign valid_o = v_ff[N-1];
   assign root_o  = root_ff[N-1];
   assign nmag_o  = m_ff[N-1];
   assign side_o  = sd_ff[N-1];

endmodule

`default_nettype wire

// ----- hw/rtl/tfn_div.sv -----
// tfn_div: rounded divide of three magnitudes by the length, one quotient bit per stage,
// then saturation, sign and the degenerate override. Depends on tfn_pkg.
`default_nettype none

module tfn_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_i,
   input  logic [tfn_pkg::RW-1:0]        root_i,
   input  logic [2:0][tfn_pkg::NW-1:0]   nmag_i,
   input  tfn_pkg::side_type             side_i,
   output logic                          valid_o,
   output logic [2:0][tfn_pkg::OW-1:0]   normal_o,
   output logic                          degen_o
);

   localparam int N   = tfn_pkg::QW;
   localparam int DW  = tfn_pkg::DNW;
   localparam int RMW = tfn_pkg::RW + 1;

   // numerator stage
   logic                   v0_ff;
   logic [2:0][DW-1:0]     num0_ff, num0_in;
   logic [tfn_pkg::RW-1:0] l0_ff;
   tfn_pkg::side_type      sd0_ff;

   logic                   v_ff   [N];
   logic [2:0][DW-1:0]     num_ff [N];
   logic [tfn_pkg::RW-1:0] l_ff   [N];
   logic [2:0][RMW-1:0]    rem_ff [N];
   logic [2:0][N-1:0]      q_ff   [N];
   tfn_pkg::side_type      sd_ff  [N];

   logic                         vo_ff;
   logic [2:0][tfn_pkg::OW-1:0]  nrm_ff, nrm_in;
   logic                         dg_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num0_in[i] = DW'({nmag_i[i], 14'd0}) + DW'(root_i >> 1);
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      logic                   v_prev;
      logic [2:0][DW-1:0]     num_prev;
      logic [tfn_pkg::RW-1:0] l_prev;
      logic [2:0][RMW-1:0]    rem_prev, rem_in;
      logic [2:0][N-1:0]      q_prev, q_in;
      tfn_pkg::side_type      sd_prev;
      logic [RMW:0]           pre [3];

      if (k == 0) begin : g_first
         assign v_prev   = v0_ff;
         assign num_prev = num0_ff;
         assign l_prev   = l0_ff;
         assign sd_prev  = sd0_ff;
         assign q_prev   = '0;
         for (genvar i = 0; i < 3; i++) begin : g_init
            assign rem_prev[i] = RMW'(num0_ff[i][DW-1:N]);
         end
      end else begin : g_next
         assign v_prev   = v_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign l_prev   = l_ff[k-1];
         assign sd_prev  = sd_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign rem_prev = rem_ff[k-1];
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            pre[i] = {rem_prev[i], num_prev[i][N-1-k]};
            if (pre[i] >= (RMW+1)'(l_prev)) begin
               rem_in[i] = RMW'(pre[i] - (RMW+1)'(l_prev));
               q_in[i]   = {q_prev[i][N-2:0], 1'b1};
            end else begin
               rem_in[i] = RMW'(pre[i]);
               q_in[i]   = {q_prev[i][N-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         num_ff[k] <= num_prev;
         l_ff[k]   <= l_prev;
         rem_ff[k] <= rem_in;
         q_ff[k]   <= q_in;
         sd_ff[k]  <= sd_prev;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [N-1:0] q;
         q = q_ff[N-1][i];
         if (q > tfn_pkg::UNIT) q = tfn_pkg::UNIT;
         if (sd_ff[N-1].degen) begin
            nrm_in[i] = '0;
         end else if (sd_ff[N-1].neg[i]) begin
            nrm_in[i] = -tfn_pkg::OW'(q);
         end else begin
            nrm_in[i] = tfn_pkg::OW'(q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v0_ff <= valid_i;
         vo_ff <= v_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      num0_ff <= num0_in;
      l0_ff   <= root_i;
      sd0_ff  <= side_i;
      nrm_ff  <= nrm_in;
      dg_ff   <= sd_ff[N-1].degen;
   end

   assign valid_o  = vo_ff;
   assign normal_o = nrm_ff;
   assign degen_o  = dg_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/triangle_face_normal_core.sv -----
// triangle_face_normal_core: top level of the unit face normal pipeline.
// Depends on tfn_pkg, tfn_cross, tfn_norm, tfn_isqrt and tfn_div.
//
//   channel   | handshake          | payload
//   ----------+--------------------+------------------------------------------
//   request   | start / busy       | req_vertex_{a,b,c}_{x,y,z}, Q12.12
//   response  | rsp_valid (strobe) | rsp_normal_{x,y,z} Q1.14, rsp_degenerate
//
// One transaction enters per cycle; busy is always low.
// The pipeline runs through the cross product, normalize and square, square
// root (one root bit per stage), divide (a numerator stage, then one quotient
// bit per stage for 15 bits) and one output register.
// Synchronous reset clears the valid bits of every stage; data needs none.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module triangle_face_normal_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [23:0] req_vertex_a_x,
   input  logic [23:0] req_vertex_a_y,
   input  logic [23:0] req_vertex_a_z,
   input  logic [23:0] req_vertex_b_x,
   input  logic [23:0] req_vertex_b_y,
   input  logic [23:0] req_vertex_b_z,
   input  logic [23:0] req_vertex_c_x,
   input  logic [23:0] req_vertex_c_y,
   input  logic [23:0] req_vertex_c_z,
   output logic        rsp_valid,
   output logic [15:0] rsp_normal_x,
   output logic [15:0] rsp_normal_y,
   output logic [15:0] rsp_normal_z,
   output logic        rsp_degenerate
);

   logic                                cr_valid;
   logic [2:0][tfn_pkg::MW-1:0]         cr_mag;
   logic [2:0]                          cr_neg;

   logic                                nm_valid;
   logic [tfn_pkg::SW-1:0]              nm_sum;
   logic [2:0][tfn_pkg::NW-1:0]         nm_mag;
   tfn_pkg::side_type                   nm_side;

   logic                                sq_valid;
   logic [tfn_pkg::RW-1:0]              sq_root;
   logic [2:0][tfn_pkg::NW-1:0]         sq_mag;
   tfn_pkg::side_type                   sq_side;

   logic [2:0][tfn_pkg::OW-1:0]         normal;

   // never stalls
   assign busy = 1'b0;

   tfn_cross u_cross (
      .clock   (clock),
      .reset   (reset),
      .valid_i (start),
      .va_i    ({req_vertex_a_z, req_vertex_a_y, req_vertex_a_x}),
      .vb_i    ({req_vertex_b_z, req_vertex_b_y, req_vertex_b_x}),
      .vc_i    ({req_vertex_c_z, req_vertex_c_y, req_vertex_c_x}),
      .valid_o (cr_valid),
      .mag_o   (cr_mag),
      .neg_o   (cr_neg)
   );

   tfn_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .valid_i (cr_valid),
      .mag_i   (cr_mag),
      .neg_i   (cr_neg),
      .valid_o (nm_valid),
      .sum_o   (nm_sum),
      .nmag_o  (nm_mag),
      .side_o  (nm_side)
   );

   tfn_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .valid_i (nm_valid),
      .sum_i   (nm_sum),
      .nmag_i  (nm_mag),
      .side_i  (nm_side),
      .valid_o (sq_valid),
      .root_o  (sq_root),
      .nmag_o  (sq_mag),
      .side_o  (sq_side)
   );

   tfn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .valid_i  (sq_valid),
      .root_i   (sq_root),
      .nmag_i   (sq_mag),
      .side_i   (sq_side),
      .valid_o  (rsp_valid),
      .normal_o (normal),
      .degen_o  (rsp_degenerate)
   );

   assign rsp_normal_x = normal[0];
   assign rsp_normal_y = normal[1];
   assign rsp_normal_z = normal[2];

   // a degenerate face reports a zero vector
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate result with nonzero normal");

   // components stay within plus or minus one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ($signed(rsp_normal_x) <= 16384 && $signed(rsp_normal_x) >= -16384) &&
         ($signed(rsp_normal_y) <= 16384 && $signed(rsp_normal_y) >= -16384) &&
         ($signed(rsp_normal_z) <= 16384 && $signed(rsp_normal_z) >= -16384))
      else $error("normal component out of range");

   // reset flushes the pipeline
   a_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response strobe right after reset");

endmodule

`default_nettype wire

// ----- tb/tb_triangle_face_normal_core.sv -----
// Testbench for triangle_face_normal_core: random and directed faces, checked
// against an in-bench unit normal predictor held in a small scoreboard class.
// Depends on tfn_pkg and the RTL of the core.

class normal_scoreboard;
   typedef struct {
      logic [15:0] nx, ny, nz;
      logic        degen;
   } normal_type;

   normal_type pending[$];
   int         errors;

   // integer square root of a 62-bit sum
   function automatic logic [63:0] root_of(logic [63:0] v);
      logic [63:0] res, bit_v;
      res   = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v   = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // note one accepted face: compute its expected normal
   function void note_face(logic signed [23:0] v[9]);
      longint      e1x, e1y, e1z, e2x, e2y, e2z;
      longint      cr[3];
      logic [63:0] mg[3];
      logic [63:0] m, sum, len, n;
      normal_type  r;
      e1x = longint'(v[3]) - longint'(v[0]);
      e1y = longint'(v[4]) - longint'(v[1]);
      e1z = longint'(v[5]) - longint'(v[2]);
      e2x = longint'(v[6]) - longint'(v[0]);
      e2y = longint'(v[7]) - longint'(v[1]);
      e2z = longint'(v[8]) - longint'(v[2]);
      cr[0] = e1y * e2z - e1z * e2y;
      cr[1] = e1z * e2x - e1x * e2z;
      cr[2] = e1x * e2y - e1y * e2x;
      for (int i = 0; i < 3; i++) mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
      m = mg[0];
      if (mg[1] > m) m = mg[1];
      if (mg[2] > m) m = mg[2];
      r.degen = (m == 0);
      r.nx = 0; r.ny = 0; r.nz = 0;
      if (m != 0) begin
         while (m >= (64'd1 << 30)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
         end
         while (m < (64'd1 << 29)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
         end
         sum = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
         len = root_of(sum);
         if (len == 0) len = 1;
         for (int i = 0; i < 3; i++) begin
            n = ((mg[i] << 14) + (len >> 1)) / len;
            if (n > 16384) n = 16384;
            if (cr[i] < 0) n = -n;
            if (i == 0) r.nx = n[15:0];
            else if (i == 1) r.ny = n[15:0];
            else r.nz = n[15:0];
         end
      end
      pending = {pending, r};
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_normal(logic [15:0] nx, ny, nz, logic degen);
      normal_type e;
      if (pending.size() == 0) begin
         report("response with no face outstanding");
         return;
      end
      e = pending.pop_front();
      if (nx !== e.nx) report($sformatf("normal_x %h, want %h", nx, e.nx));
      if (ny !== e.ny) report($sformatf("normal_y %h, want %h", ny, e.ny));
      if (nz !== e.nz) report($sformatf("normal_z %h, want %h", nz, e.nz));
      if (degen !== e.degen) report($sformatf("degenerate %b, want %b", degen, e.degen));
   endtask
endclass

module tb_triangle_face_normal_core;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [23:0] vtx[9] = '{default: '0};
   logic        rsp_valid;
   logic [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic        rsp_degenerate;

   normal_scoreboard normals = new();

   localparam logic [23:0] VMAX = 24'h7FFFFF;
   localparam logic [23:0] VMIN = 24'h800000;

   always #5 clock = ~clock;

   triangle_face_normal_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vertex_a_x(vtx[0]), .req_vertex_a_y(vtx[1]), .req_vertex_a_z(vtx[2]),
      .req_vertex_b_x(vtx[3]), .req_vertex_b_y(vtx[4]), .req_vertex_b_z(vtx[5]),
      .req_vertex_c_x(vtx[6]), .req_vertex_c_y(vtx[7]), .req_vertex_c_z(vtx[8]),
      .rsp_valid(rsp_valid), .rsp_normal_x(rsp_normal_x),
      .rsp_normal_y(rsp_normal_y), .rsp_normal_z(rsp_normal_z),
      .rsp_degenerate(rsp_degenerate)
   );

   // Sample the request side at the rising edge: a transaction is start & !busy.
   always @(posedge clock) begin
      logic signed [23:0] f[9];
      if (!reset && start && !busy) begin
         for (int i = 0; i < 9; i++) f[i] = vtx[i];
         normals.note_face(f);
      end
      if (!reset && rsp_valid)
         normals.check_normal(rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_degenerate);
   end

   // Mostly short gaps, a few long ones; a zero gap keeps start high back to back.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 70);
   endfunction

   // Present one face at the falling edge and hold until the block takes it.
   task send_face(logic [23:0] f[9]);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
      for (int i = 0; i < 9; i++) vtx[i] <= f[i];
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Random coordinate: full range, extremes, or small values for fine detail.
   function automatic logic [23:0] rand_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return 24'($urandom());
      if (r == 5) return $urandom_range(0, 1) ? VMAX : VMIN;
      return 24'($signed($urandom_range(0, 4096)) - 2048);
   endfunction

   task run_directed();
      logic [23:0] f[9];
      // three equal vertices: degenerate
      foreach (f[i]) f[i] = 24'h001000;
      send_face(f);
      // all zero
      foreach (f[i]) f[i] = 0;
      send_face(f);
      // axis aligned unit triangles, both windings
      f = '{0, 0, 0, 24'h001000, 0, 0, 0, 24'h001000, 0};
      send_face(f);
      f = '{0, 0, 0, 0, 24'h001000, 0, 24'h001000, 0, 0};
      send_face(f);
      f = '{0, 0, 0, 0, 24'h001000, 0, 0, 0, 24'h001000};
      send_face(f);
      // collinear points
      f = '{0, 0, 0, 24'h000010, 24'h000020, 24'h000030, 24'h000020, 24'h000040, 24'h000060};
      send_face(f);
      // extreme corners: largest cross product magnitudes
      f = '{VMIN, VMIN, VMIN, VMAX, VMIN, VMIN, VMIN, VMAX, VMIN};
      send_face(f);
      f = '{VMAX, VMAX, VMAX, VMIN, VMAX, VMAX, VMAX, VMIN, VMAX};
      send_face(f);
      f = '{VMIN, VMAX, VMIN, VMAX, VMIN, VMAX, VMIN, VMIN, VMAX};
      send_face(f);
      f = '{VMAX, VMIN, VMAX, VMIN, VMAX, VMIN, VMAX, VMAX, VMIN};
      send_face(f);
      // tiny triangle: smallest nonzero cross product, left shift path; then c equal to a
      f = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
      send_face(f);
      f = '{VMAX, VMAX, VMAX, VMIN, VMAX, VMAX, VMAX, VMAX, VMAX};
      send_face(f);
      // diagonal normal, all components equal
      f = '{24'h001000, 0, 0, 0, 24'h001000, 0, 0, 0, 24'h001000};
      send_face(f);
      f = '{24'hFFF000, 0, 0, 0, 24'hFFF000, 0, 0, 0, 24'hFFF000};
      send_face(f);
   endtask

   initial begin
      logic [23:0] f[9];
      int          k;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      run_directed();
      for (int n = 0; n < 1650; n++) begin
         k = $urandom_range(0, 19);
         foreach (f[i]) f[i] = rand_coord();
         if (k == 0) begin
            // one vertex repeated: degenerate face
            f[3] = f[0]; f[4] = f[1]; f[5] = f[2];
         end else if (k == 1) begin
            // c on the line through a and b
            for (int i = 0; i < 3; i++)
               f[6 + i] = 24'(f[i] + 2 * (f[3 + i] - f[i]));
         end
         send_face(f);
      end
      start <= 0;
      while (normals.pending.size() != 0) @(posedge clock);
      repeat (tfn_pkg::LATENCY + 10) @(posedge clock);
      if (normals.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog: stops the run far beyond the worst case for all faces.
   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
